// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DSRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Antecedent holds, consequent must hold in the next cycle.
`define DSRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== sv/dsrm_pkg.sv =====
// Shared constants and types for the dot-star matcher.
`default_nettype none
package dsrm_pkg;

  localparam int unsigned MaxElements = 32;

  localparam logic [7:0] SymAny  = 8'h2E;
  localparam logic [7:0] SymStar = 8'h2A;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdStart  = 2'd2;
  localparam logic [1:0] CmdByte   = 2'd3;

  typedef struct packed {
    logic clear_pat;
    logic drop_act;
    logic start;
    logic step;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/dot_star_regex_matcher_core.sv =====
// Dot-star matcher: row of element cells with an output word register.
// A start or subject-byte word gives its result word in the next cycle.
// Throughput: one input word per cycle while the output is not stalled; the
// star closure ripples through the cell row within that cycle, so its length
// bounds the clock period. Clear and append words give no result. Reset
// empties the pattern, the active set and the output valid flag at once.
`default_nettype none
module dot_star_regex_matcher_core import dsrm_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElements
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [1:0] cmd_i,
  input  wire  [7:0] data_byte_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  logic                  accept;
  cell_ctrl_t            ctrl;
  logic                  append_sym, append_star, full;
  logic [CntW-1:0]       count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [MAX_ELEMENTS:0] fwd;
  logic [MAX_ELEMENTS:0] pos_next;
  logic                  out_valid_q, matched_q, out_ovf_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ctrl.clear_pat = accept && (cmd_i == CmdClear);
  assign ctrl.drop_act  = accept && ((cmd_i == CmdClear) || (cmd_i == CmdAppend));
  assign ctrl.start     = accept && (cmd_i == CmdStart);
  assign ctrl.step      = accept && (cmd_i == CmdByte);
  assign append_sym     = accept && (cmd_i == CmdAppend) && (data_byte_i != SymStar);
  assign append_star    = accept && (cmd_i == CmdAppend) && (data_byte_i == SymStar);
  assign full           = (count_q == CntW'(MAX_ELEMENTS));

  assign fwd[0] = ctrl.start;

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    dsrm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .data_byte_i (data_byte_i),
      .wr_sym_i    (append_sym && (count_q == CntW'(k))),
      .set_star_i  (append_star && (count_q == CntW'(k + 1))),
      .fwd_i       (fwd[k]),
      .fwd_o       (fwd[k+1]),
      .act_next_o  (pos_next[k])
    );
  end

  assign pos_next[MAX_ELEMENTS] = fwd[MAX_ELEMENTS];

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctrl.clear_pat) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (append_sym) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (ctrl.start || ctrl.step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.start || ctrl.step) begin
      matched_q <= pos_next[count_q] & ~ovf_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = out_ovf_q;

endmodule
`default_nettype wire

// ===== sv/dsrm_cell.sv =====
// One pattern element cell: symbol, star flag and active bit of its position.
`default_nettype none
module dsrm_cell import dsrm_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  wire  [7:0]  data_byte_i,
  input  wire         wr_sym_i,
  input  wire         set_star_i,
  input  wire         fwd_i,
  output logic        fwd_o,
  output logic        act_next_o
);

  logic [7:0] sym_q;
  logic       star_q, star_d;
  logic       valid_q, valid_d;
  logic       act_q, act_d;
  logic       hit;
  logic       self_term;

  assign hit        = (sym_q == SymAny) || (sym_q == data_byte_i);
  assign self_term  = ctrl_i.step & valid_q & act_q & hit & star_q;
  assign act_next_o = self_term | fwd_i;
  assign fwd_o      = valid_q & ((act_next_o & star_q) |
                                 (ctrl_i.step & act_q & hit & ~star_q));

  always_comb begin
    star_d  = star_q;
    valid_d = valid_q;
    act_d   = act_q;
    if (ctrl_i.clear_pat) begin
      star_d  = 1'b0;
      valid_d = 1'b0;
    end else if (wr_sym_i) begin
      star_d  = 1'b0;
      valid_d = 1'b1;
    end else if (set_star_i) begin
      star_d = 1'b1;
    end
    if (ctrl_i.drop_act) begin
      act_d = 1'b0;
    end else if (ctrl_i.start || ctrl_i.step) begin
      act_d = act_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      star_q  <= 1'b0;
      valid_q <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      star_q  <= star_d;
      valid_q <= valid_d;
      act_q   <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sym_i) begin
      sym_q <= data_byte_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dsrm_checker.sv =====
// Port-level checks for the dot-star matcher, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module dsrm_checker import dsrm_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire [1:0] cmd_i,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire       matched_o,
  input wire       pattern_overflow_o
);

  `DSRM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `DSRM_ASSERT(a_no_match_on_ovf, clk_i, rst_ni, !(out_valid_o && matched_o && pattern_overflow_o))
  `DSRM_ASSERT(a_stall_only_when_full, clk_i, rst_ni, out_valid_o || !in_stall_o)
  `DSRM_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_valid_i && !in_stall_o && ((cmd_i == CmdStart) || (cmd_i == CmdByte)), out_valid_o)

endmodule

bind dot_star_regex_matcher_core dsrm_checker u_dsrm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .cmd_i              (cmd_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .matched_o          (matched_o),
  .pattern_overflow_o (pattern_overflow_o)
);
`default_nettype wire
